/* rtl/core/mlr_pkg.sv */
// shared constants and types of the midpoint line rasterizer
`timescale 1ns / 1ps

package mlr_pkg;

    // default coordinate width and its legal range
    localparam int COORD_BITS_DEF = 6;
    localparam int COORD_BITS_MIN = 4;
    localparam int COORD_BITS_MAX = 12;

    // depth of the command queue between setup and stepper
    localparam int QUEUE_DEPTH = 2;

    // headroom bits of the decision variable over the coordinate width
    localparam int DEC_EXTRA_BITS = 4;

    // per-segment stepping mode
    typedef struct packed {
        logic x_major;       // x advances every step, else y does
        logic y_down;        // y moves toward smaller values
        logic minor_on_pos;  // minor step when d > 0, else when d <= 0
    } t_mode;

endpackage

/* rtl/core/mlr_ifs.sv */
// channel interfaces of the midpoint line rasterizer
`timescale 1ns / 1ps

interface mlr_seg_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_cmd_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] count;
    logic signed [DW-1:0]  d0;
    logic signed [DW-1:0]  inc_minor;
    logic signed [DW-1:0]  inc_major;
    mlr_pkg::t_mode        mode;

    modport source (output valid, x0, y0, count, d0, inc_minor, inc_major, mode,
                    input ready);
    modport sink   (input valid, x0, y0, count, d0, inc_minor, inc_major, mode,
                    output ready);
endinterface

interface mlr_pix_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

/* rtl/core/midpoint_line_rasterizer_core.sv */
// top level of the midpoint line rasterizer
// latency: first pixel passes queue entry, walk registers and output register (empty pipe)
// throughput: one pixel per cycle while the pixel output is not stalled; a segment is loaded
//   only while the stepper is idle; set by the single decision-variable loop in the stepper
// up to two segments wait in the command queue, so input transactions continue during a walk
// reset: synchronous active low, clears queue pointers and valid flags; no clearing pass
`timescale 1ns / 1ps

module midpoint_line_rasterizer_core #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
    parameter int DEPTH      = mlr_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlr_seg_if.sink   i_seg,   // segment transactions in
    mlr_pix_if.source o_pix    // pixel transactions out
);

    // setup to queue, and queue to stepper
    mlr_cmd_if #(.COORD_BITS(COORD_BITS)) setup_cmd ();
    mlr_cmd_if #(.COORD_BITS(COORD_BITS)) step_cmd ();

    // front: swap endpoints, pick the octant pair, compute d and its increments
    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_seg (i_seg),
        .o_cmd (setup_cmd)
    );

    // decouples setup from the stepper so each side stalls on its own
    mlr_queue #(
        .COORD_BITS (COORD_BITS),
        .DEPTH      (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (setup_cmd),
        .o_cmd   (step_cmd)
    );

    // back: walk the segment, registered pixel output
    mlr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (step_cmd),
        .o_pix   (o_pix)
    );

endmodule

/* rtl/core/mlr_setup.sv */
// segment setup: endpoint swap, case selection and decision terms
`timescale 1ns / 1ps

module mlr_setup #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    mlr_seg_if.sink   i_seg,
    mlr_cmd_if.source o_cmd
);
    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    logic                 swap;
    logic [COORD_BITS-1:0] x0, y0, xe, ye;
    logic signed [DW-1:0] dx, dy, ndy;
    mlr_pkg::t_mode       mode;

    assign swap = i_seg.x_end < i_seg.x_start;
    assign x0   = swap ? i_seg.x_end   : i_seg.x_start;
    assign y0   = swap ? i_seg.y_end   : i_seg.y_start;
    assign xe   = swap ? i_seg.x_start : i_seg.x_end;
    assign ye   = swap ? i_seg.y_start : i_seg.y_end;

    assign dx  = DW'(xe) - DW'(x0);
    assign dy  = DW'(ye) - DW'(y0);
    assign ndy = -dy;

    always_comb begin
        if (dy >= 0 && dy <= dx) begin
            // shallow rising
            mode              = '{x_major: 1'b1, y_down: 1'b0, minor_on_pos: 1'b0};
            o_cmd.d0          = dx - (dy <<< 1);
            o_cmd.inc_minor   = (dx - dy) <<< 1;
            o_cmd.inc_major   = -(dy <<< 1);
            o_cmd.count       = dx[COORD_BITS-1:0];
        end else if (dy < 0 && ndy <= dx) begin
            // shallow falling
            mode              = '{x_major: 1'b1, y_down: 1'b1, minor_on_pos: 1'b1};
            o_cmd.d0          = (ndy <<< 1) - dx;
            o_cmd.inc_minor   = (ndy - dx) <<< 1;
            o_cmd.inc_major   = ndy <<< 1;
            o_cmd.count       = dx[COORD_BITS-1:0];
        end else if (dy > dx) begin
            // steep rising
            mode              = '{x_major: 1'b0, y_down: 1'b0, minor_on_pos: 1'b1};
            o_cmd.d0          = (dx <<< 1) - dy;
            o_cmd.inc_minor   = (dx - dy) <<< 1;
            o_cmd.inc_major   = dx <<< 1;
            o_cmd.count       = dy[COORD_BITS-1:0];
        end else begin
            // steep falling
            mode              = '{x_major: 1'b0, y_down: 1'b1, minor_on_pos: 1'b0};
            o_cmd.d0          = ndy - (dx <<< 1);
            o_cmd.inc_minor   = (ndy - dx) <<< 1;
            o_cmd.inc_major   = -(dx <<< 1);
            o_cmd.count       = ndy[COORD_BITS-1:0];
        end
    end

    assign o_cmd.mode  = mode;
    assign o_cmd.x0    = x0;
    assign o_cmd.y0    = y0;
    assign o_cmd.valid = i_seg.valid;
    assign i_seg.ready = o_cmd.ready;

endmodule

/* rtl/core/mlr_queue.sv */
// small command queue between setup and stepper
`timescale 1ns / 1ps

module mlr_queue #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
    parameter int DEPTH      = mlr_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlr_cmd_if.sink   i_cmd,
    mlr_cmd_if.source o_cmd
);
    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [COORD_BITS-1:0] r_x0    [DEPTH];
    logic [COORD_BITS-1:0] r_y0    [DEPTH];
    logic [COORD_BITS-1:0] r_count [DEPTH];
    logic signed [DW-1:0]  r_d0    [DEPTH];
    logic signed [DW-1:0]  r_inc_mi[DEPTH];
    logic signed [DW-1:0]  r_inc_ma[DEPTH];
    mlr_pkg::t_mode        r_mode  [DEPTH];

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_fill,   n_fill;
    logic          push, pop;

    assign i_cmd.ready = r_fill != CW'(DEPTH);
    assign o_cmd.valid = r_fill != '0;
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = o_cmd.valid && o_cmd.ready;

    assign o_cmd.x0        = r_x0[r_rd_ptr];
    assign o_cmd.y0        = r_y0[r_rd_ptr];
    assign o_cmd.count     = r_count[r_rd_ptr];
    assign o_cmd.d0        = r_d0[r_rd_ptr];
    assign o_cmd.inc_minor = r_inc_mi[r_rd_ptr];
    assign o_cmd.inc_major = r_inc_ma[r_rd_ptr];
    assign o_cmd.mode      = r_mode[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + CW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_x0[r_wr_ptr]     <= i_cmd.x0;
            r_y0[r_wr_ptr]     <= i_cmd.y0;
            r_count[r_wr_ptr]  <= i_cmd.count;
            r_d0[r_wr_ptr]     <= i_cmd.d0;
            r_inc_mi[r_wr_ptr] <= i_cmd.inc_minor;
            r_inc_ma[r_wr_ptr] <= i_cmd.inc_major;
            r_mode[r_wr_ptr]   <= i_cmd.mode;
        end
    end

endmodule

/* rtl/core/mlr_stepper.sv */
// pixel stepper: walks one segment and emits a pixel per cycle while the output is not stalled
`timescale 1ns / 1ps

module mlr_stepper #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlr_cmd_if.sink   i_cmd,
    mlr_pix_if.source o_pix
);
    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    // walk state
    logic                  r_busy;
    logic [COORD_BITS-1:0] r_x, r_y, r_cnt;
    logic signed [DW-1:0]  r_d, r_inc_mi, r_inc_ma;
    mlr_pkg::t_mode        r_mode;

    // output register
    logic                  r_ovalid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_plast;

    logic                  load, emit, can_emit, take_minor, move_y, last;
    logic [COORD_BITS-1:0] n_x, n_y;
    logic signed [DW-1:0]  n_d;

    assign can_emit    = !r_ovalid || o_pix.ready;
    assign i_cmd.ready = !r_busy;
    assign load        = i_cmd.valid && !r_busy;
    assign emit        = r_busy && can_emit;
    assign last        = r_cnt == '0;

    assign take_minor = r_mode.minor_on_pos ? (r_d > 0) : (r_d <= 0);
    assign move_y     = !r_mode.x_major || take_minor;
    assign n_d        = r_d + (take_minor ? r_inc_mi : r_inc_ma);
    assign n_x        = r_x + COORD_BITS'(r_mode.x_major || take_minor);
    assign n_y        = !move_y ? r_y :
                        r_mode.y_down ? r_y - COORD_BITS'(1) : r_y + COORD_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x      <= i_cmd.x0;
            r_y      <= i_cmd.y0;
            r_cnt    <= i_cmd.count;
            r_d      <= i_cmd.d0;
            r_inc_mi <= i_cmd.inc_minor;
            r_inc_ma <= i_cmd.inc_major;
            r_mode   <= i_cmd.mode;
        end else if (emit) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_d   <= n_d;
            r_cnt <= r_cnt - COORD_BITS'(1);
        end
        if (emit) begin
            r_px    <= r_x;
            r_py    <= r_y;
            r_plast <= last;
        end
    end

    assign o_pix.valid      = r_ovalid;
    assign o_pix.pixel_x    = r_px;
    assign o_pix.pixel_y    = r_py;
    assign o_pix.last_pixel = r_plast;

endmodule

/* verif/tb_top.sv */
// self-checking testbench of the midpoint line rasterizer core
`timescale 1ns / 1ps

module tb_top;

    localparam int CB              = mlr_pkg::COORD_BITS_DEF;
    localparam int CMAX            = (1 << CB) - 1;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 20;

    typedef struct {
        logic [CB-1:0] pixel_x;
        logic [CB-1:0] pixel_y;
        logic          last_pixel;
    } t_pixel;

    logic clk = 1'b0;
    logic rst_n;

    // pixels still owed by the block, oldest first
    t_pixel expected_pixels[$];
    int     fail_count    = 0;
    int     quiet_cycles  = 0;
    int     hold_off_left = 0;
    bit     send_gaps     = 1'b0;
    bit     pixel_stalls  = 1'b0;

    mlr_seg_if #(.COORD_BITS(CB)) seg_if ();
    mlr_pix_if #(.COORD_BITS(CB)) pix_if ();

    midpoint_line_rasterizer_core #(
        .COORD_BITS(CB)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_seg   (seg_if.sink),
        .o_pix   (pix_if.source)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walk one segment with integer midpoint decisions and queue its pixels
    function automatic void rasterize_segment(input logic [CB-1:0] xs, ys, xe, ye);
        t_pixel seg_pix[$];
        int x0, y0, x1, y1, dx, dy, d, x, y, tmp;
        x0 = xs;
        y0 = ys;
        x1 = xe;
        y1 = ye;
        if (x1 < x0) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        x  = x0;
        y  = y0;
        seg_pix.push_back('{CB'(x), CB'(y), 1'b0});
        if (dy >= 0 && dy <= dx) begin
            // shallow rising: diagonal when d <= 0
            d = dx - 2 * dy;
            while (x < x1) begin
                if (d <= 0) begin
                    x++; y++; d += 2 * (dx - dy);
                end else begin
                    x++; d -= 2 * dy;
                end
                seg_pix.push_back('{CB'(x), CB'(y), 1'b0});
            end
        end else if (dy < 0 && dy >= -dx) begin
            // shallow falling: go down when d > 0
            d = -2 * dy - dx;
            while (x < x1) begin
                if (d > 0) begin
                    x++; y--; d += -2 * dy - 2 * dx;
                end else begin
                    x++; d += -2 * dy;
                end
                seg_pix.push_back('{CB'(x), CB'(y), 1'b0});
            end
        end else if (dy > dx) begin
            // steep rising: move x too when d > 0
            d = 2 * dx - dy;
            while (y < y1) begin
                if (d > 0) begin
                    x++; y++; d += 2 * (dx - dy);
                end else begin
                    y++; d += 2 * dx;
                end
                seg_pix.push_back('{CB'(x), CB'(y), 1'b0});
            end
        end else begin
            // steep falling: move x too when d <= 0
            d = -dy - 2 * dx;
            while (y > y1) begin
                if (d <= 0) begin
                    x++; y--; d += 2 * (-dy - dx);
                end else begin
                    y--; d -= 2 * dx;
                end
                seg_pix.push_back('{CB'(x), CB'(y), 1'b0});
            end
        end
        seg_pix[$].last_pixel = 1'b1;
        foreach (seg_pix[i]) expected_pixels.push_back(seg_pix[i]);
    endfunction

    // point within a few steps of c, kept on the grid
    function automatic int near(input int c);
        int v;
        v = c + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > CMAX) v = CMAX;
        return v;
    endfunction

    // predict on accepted segments, check accepted pixels
    always @(posedge clk) begin : pixel_check
        t_pixel want;
        if (rst_n) begin
            if (seg_if.valid && seg_if.ready)
                rasterize_segment(seg_if.x_start, seg_if.y_start, seg_if.x_end, seg_if.y_end);
            if (pix_if.valid && pix_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual (%0d, %0d) last %0b",
                             $time, pix_if.pixel_x, pix_if.pixel_y, pix_if.last_pixel);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (pix_if.pixel_x !== want.pixel_x) begin
                        $display("%0t: pixel_x mismatch, expected %0d, actual %0d",
                                 $time, want.pixel_x, pix_if.pixel_x);
                        fail_count++;
                    end
                    if (pix_if.pixel_y !== want.pixel_y) begin
                        $display("%0t: pixel_y mismatch, expected %0d, actual %0d",
                                 $time, want.pixel_y, pix_if.pixel_y);
                        fail_count++;
                    end
                    if (pix_if.last_pixel !== want.last_pixel) begin
                        $display("%0t: last_pixel mismatch, expected %0b, actual %0b",
                                 $time, want.last_pixel, pix_if.last_pixel);
                        fail_count++;
                    end
                end
            end
        end
    end

    // pixel receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (hold_off_left > 0) begin
            pix_if.ready <= 1'b0;
            hold_off_left--;
        end else if (pixel_stalls) begin
            pix_if.ready <= ($urandom_range(0, 99) >= 33);
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    // ends the run when no transaction moves for too long
    always @(posedge clk) begin
        if ((seg_if.valid && seg_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one segment, optionally after a gap, and wait for its transaction
    task automatic send_segment(input int xs, ys, xe, ye);
        if (send_gaps && $urandom_range(0, 99) < 33) begin
            seg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.x_start <= CB'(xs);
        seg_if.y_start <= CB'(ys);
        seg_if.x_end   <= CB'(xe);
        seg_if.y_end   <= CB'(ye);
        do @(posedge clk); while (!(seg_if.valid && seg_if.ready));
    endtask

    // sender pauses until every owed pixel has come out
    // it waits on the clock first so the checker has queued the last accepted segment
    task automatic wait_for_pixels();
        seg_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_segments();
        send_gaps    = 1'b0;
        pixel_stalls = 1'b0;
        // single points at both corners
        send_segment(0, 0, 0, 0);
        send_segment(CMAX, CMAX, CMAX, CMAX);
        // full-length horizontal, both directions
        send_segment(0, 5, CMAX, 5);
        send_segment(CMAX, 40, 0, 40);
        // vertical, up and down
        send_segment(10, 0, 10, CMAX);
        send_segment(50, CMAX, 50, 0);
        // diagonals on the octant borders
        send_segment(0, 0, CMAX, CMAX);
        send_segment(0, CMAX, CMAX, 0);
        send_segment(CMAX, CMAX, 0, 0);
        send_segment(CMAX, 0, 0, CMAX);
        // one segment per octant case, then swapped
        send_segment(2, 3, 40, 20);
        send_segment(40, 20, 2, 3);
        send_segment(2, 40, 50, 10);
        send_segment(50, 10, 2, 40);
        send_segment(5, 5, 20, 60);
        send_segment(20, 60, 5, 5);
        send_segment(5, 60, 20, 2);
        send_segment(20, 2, 5, 60);
        // nearly vertical and nearly horizontal extremes
        send_segment(0, 0, 1, CMAX);
        send_segment(CMAX, 0, CMAX - 1, CMAX);
        send_segment(0, CMAX, CMAX, CMAX - 1);
        send_segment(3, 7, 4, 7);
        wait_for_pixels();
    endtask

    // mix of long, short, axis-aligned and diagonal segments
    task automatic send_random_segment();
        int xs, ys, xe, ye, k;
        xs = $urandom_range(0, CMAX);
        ys = $urandom_range(0, CMAX);
        xe = $urandom_range(0, CMAX);
        ye = $urandom_range(0, CMAX);
        case ($urandom_range(0, 5))
            2, 3: begin
                xe = near(xs);
                ye = near(ys);
            end
            4: begin
                if ($urandom_range(0, 1)) ye = ys;
                else xe = xs;
            end
            5: begin
                k  = $urandom_range(0, CMAX - ((xs > ys) ? xs : ys));
                xe = xs + k;
                ye = ys + k;
                if ($urandom_range(0, 1)) begin
                    ys = CMAX - ys;
                    ye = CMAX - ye;
                end
            end
            default: ;
        endcase
        if ($urandom_range(0, 1))
            send_segment(xe, ye, xs, ys);
        else
            send_segment(xs, ys, xe, ye);
    endtask

    task automatic test_random_segments(input int n);
        send_gaps    = 1'b1;
        pixel_stalls = 1'b1;
        repeat (n) send_random_segment();
        wait_for_pixels();
    endtask

    // no idling on either side: segments queue up behind the walk
    task automatic test_back_to_back(input int n);
        send_gaps    = 1'b0;
        pixel_stalls = 1'b0;
        repeat (n) send_random_segment();
        wait_for_pixels();
    endtask

    // receiver holds off while segments keep coming, so the input stalls
    task automatic test_output_hold_off(input int n);
        send_gaps     = 1'b0;
        pixel_stalls  = 1'b1;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (n) send_segment($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                                $urandom_range(0, CMAX), $urandom_range(0, CMAX));
        wait_for_pixels();
    endtask

    initial begin
        seg_if.valid   <= 1'b0;
        seg_if.x_start <= '0;
        seg_if.y_start <= '0;
        seg_if.x_end   <= '0;
        seg_if.y_end   <= '0;
        rst_n          <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_segments();
        test_random_segments(120);
        test_output_hold_off(16);
        test_back_to_back(60);
        test_random_segments(80);

        wait_for_pixels();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mlr_pkg.sv
rtl/core/mlr_ifs.sv
rtl/core/mlr_setup.sv
rtl/core/mlr_queue.sv
rtl/core/mlr_stepper.sv
rtl/core/midpoint_line_rasterizer_core.sv
verif/tb_top.sv
